>>> rtl/cfot_pkg.sv
// Shared constants and types for the cube face occlusion test.
package cfot_pkg;

  // Fractional bits of the coordinate format and the face half-size shift (0.5 = 2^15 LSB)
  localparam int FRAC_BITS  = 16;
  localparam int HALF_SHIFT = FRAC_BITS - 1;

  // Configuration register indexes
  localparam logic [1:0] REG_CENTRE_X = 2'd0;
  localparam logic [1:0] REG_CENTRE_Y = 2'd1;
  localparam logic [1:0] REG_CENTRE_Z = 2'd2;

  // Blocking face codes
  localparam logic [2:0] FACE_NONE   = 3'd0;
  localparam logic [2:0] FACE_NEG_X  = 3'd1;
  localparam logic [2:0] FACE_POS_X  = 3'd2;
  localparam logic [2:0] FACE_NEG_Y  = 3'd3;
  localparam logic [2:0] FACE_POS_Y  = 3'd4;
  localparam logic [2:0] FACE_NEG_Z  = 3'd5;
  localparam logic [2:0] FACE_POS_Z  = 3'd6;

  // Block flags for the two faces of one axis
  typedef struct packed {
    logic minus;
    logic plus;
  } face_hit_t;

endpackage

>>> rtl/cfot_sqrt.sv
// Pipelined integer square root, one root bit per stage, with a side payload.
module cfot_sqrt import cfot_pkg::*; #(
  parameter int RW     = 25,
  parameter int SW     = 50,
  parameter int SIDE_W = 75
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [SW-1:0]     radicand_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [RW-1:0]     root_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              valid_q [RW+1];
  logic [SW-1:0]     rem_q   [RW+1];
  logic [RW-1:0]     root_q  [RW+1];
  logic [SIDE_W-1:0] side_q  [RW+1];

  assign valid_q[0] = valid_i;
  assign rem_q[0]   = radicand_i;
  assign root_q[0]  = '0;
  assign side_q[0]  = side_i;

  for (genvar g = 0; g < RW; g++) begin : g_stage
    localparam int K = RW - 1 - g;
    logic [SW-1:0] trial;
    logic [SW:0]   diff;

    // Growth of the square when bit K is set: r*2^(K+1) + 2^(2K)
    assign trial = (SW'(root_q[g]) << (K + 1)) | (SW'(1) << (2 * K));
    assign diff  = {1'b0, rem_q[g]} - {1'b0, trial};

    // Advance the valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g+1] <= 1'b0;
      end else begin
        valid_q[g+1] <= valid_q[g];
      end
    end

    // Keep the bit when the trial square still fits
    always_ff @(posedge clk_i) begin
      if (diff[SW]) begin
        rem_q[g+1]  <= rem_q[g];
        root_q[g+1] <= root_q[g];
      end else begin
        rem_q[g+1]  <= diff[SW-1:0];
        root_q[g+1] <= root_q[g] | (RW'(1) << K);
      end
      side_q[g+1] <= side_q[g];
    end
  end

  assign valid_o = valid_q[RW];
  assign root_o  = root_q[RW];
  assign side_o  = side_q[RW];

endmodule

>>> rtl/cfot_axis.sv
// Two-stage test of the minus and plus faces of one cube axis.
module cfot_axis import cfot_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic signed [COORD_WIDTH-1:0] ca_i,
  input  logic signed [COORD_WIDTH-1:0] cb_i,
  input  logic signed [COORD_WIDTH-1:0] cc_i,
  input  logic signed [COORD_WIDTH:0]   da_i,
  input  logic signed [COORD_WIDTH:0]   db_i,
  input  logic signed [COORD_WIDTH:0]   dc_i,
  input  logic        [COORD_WIDTH:0]   len_i,
  output logic                          valid_o,
  output face_hit_t                     hit_o
);

  localparam int W  = COORD_WIDTH;
  localparam int PW = 2 * W + 2;
  localparam int CW = 2 * W + 4;
  localparam int NW = W + 2;

  // Stage A: magnitudes, face offsets and products
  logic        [W:0]    a_mag;
  logic signed [NW-1:0] half_n, num_m, num_p;
  logic                 neg;

  assign neg    = da_i[W];
  assign a_mag  = neg ? (W+1)'(-da_i) : (W+1)'(da_i);
  assign half_n = NW'(1) <<< HALF_SHIFT;
  assign num_m  = -half_n - NW'(ca_i);
  assign num_p  = half_n - NW'(ca_i);

  logic                 valid_a_q, zero_a_q, neg_a_q, pos_m_a_q, pos_p_a_q;
  logic        [W:0]    len_a_q, amag_a_q;
  logic signed [W:0]    db_a_q, dc_a_q;
  logic signed [PW-1:0] plen_a_q, pb_a_q, pc_a_q, rb_a_q, rc_a_q;
  logic        [PW-1:0] q_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else begin
      valid_a_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_a_q  <= (da_i == '0);
    neg_a_q   <= neg;
    // Offset after sign normalisation must be positive
    pos_m_a_q <= neg ? (num_m < 0) : (num_m > 0);
    pos_p_a_q <= neg ? (num_p < 0) : (num_p > 0);
    len_a_q   <= len_i;
    amag_a_q  <= a_mag;
    db_a_q    <= db_i;
    dc_a_q    <= dc_i;
    plen_a_q  <= PW'(ca_i) * PW'($signed({1'b0, len_i}));
    pb_a_q    <= PW'(ca_i) * PW'(db_i);
    pc_a_q    <= PW'(ca_i) * PW'(dc_i);
    rb_a_q    <= PW'(cb_i) * PW'($signed({1'b0, a_mag}));
    rc_a_q    <= PW'(cc_i) * PW'($signed({1'b0, a_mag}));
    q_a_q     <= PW'(a_mag) * PW'(len_i);
  end

  // Stage B: signed bounds and compares
  logic signed [CW-1:0] hl, hb, hc, ha, plen, pb, pc, rb, rc, lim;
  logic signed [CW-1:0] sum_len, sum_b, sum_c, dif_len, dif_b, dif_c;
  logic signed [CW-1:0] nlen_m, nb_m, nc_m, nlen_p, nb_p, nc_p;
  logic signed [CW-1:0] lo_b, hi_b, lo_c, hi_c;
  logic                 hit_m, hit_p;

  assign hl   = CW'($signed({1'b0, len_a_q})) <<< HALF_SHIFT;
  assign ha   = CW'($signed({1'b0, amag_a_q})) <<< HALF_SHIFT;
  assign hb   = CW'(db_a_q) <<< HALF_SHIFT;
  assign hc   = CW'(dc_a_q) <<< HALF_SHIFT;
  assign plen = CW'(plen_a_q);
  assign pb   = CW'(pb_a_q);
  assign pc   = CW'(pc_a_q);
  assign rb   = CW'(rb_a_q);
  assign rc   = CW'(rc_a_q);
  assign lim  = CW'($signed({2'b00, q_a_q})) - CW'($signed({1'b0, amag_a_q}));

  assign sum_len = hl + plen;
  assign sum_b   = hb + pb;
  assign sum_c   = hc + pc;
  assign dif_len = plen - hl;
  assign dif_b   = pb - hb;
  assign dif_c   = pc - hc;

  // Offset times length and times the other components, sign normalised
  assign nlen_m = neg_a_q ? sum_len : -sum_len;
  assign nb_m   = neg_a_q ? sum_b : -sum_b;
  assign nc_m   = neg_a_q ? sum_c : -sum_c;
  assign nlen_p = neg_a_q ? dif_len : -dif_len;
  assign nb_p   = neg_a_q ? dif_b : -dif_b;
  assign nc_p   = neg_a_q ? dif_c : -dif_c;

  assign lo_b = -ha - rb;
  assign hi_b = ha - rb;
  assign lo_c = -ha - rc;
  assign hi_c = ha - rc;

  assign hit_m = !zero_a_q && pos_m_a_q && (nlen_m < lim) && (lo_b < nb_m) && (nb_m < hi_b)
                 && (lo_c < nc_m) && (nc_m < hi_c);
  assign hit_p = !zero_a_q && pos_p_a_q && (nlen_p < lim) && (lo_b < nb_p) && (nb_p < hi_b)
                 && (lo_c < nc_p) && (nc_p < hi_c);

  logic      valid_b_q;
  face_hit_t hit_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q <= 1'b0;
    end else begin
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_b_q.minus <= hit_m;
    hit_b_q.plus  <= hit_p;
  end

  assign valid_o = valid_b_q;
  assign hit_o   = hit_b_q;

endmodule

>>> rtl/cube_face_occlusion_test_top.sv
// Top level of the cube face occlusion test: ray set-up, length, face tests, result.
//
//  channel   | ports                                   | transfer when
//  ----------+-----------------------------------------+----------------------------
//  point in  | start, busy, point_{x,y,z}_i            | start high, busy low
//  result    | done_o, visible_o, blocking_face_o      | done_o high (one cycle)
//  config    | cfg_valid_i, cfg_ready_o, cfg_index_i,  | cfg_valid_i and cfg_ready_o
//            | cfg_data_i                              |
//
// One point enters per cycle; busy stays low. Each point passes the ray, square and
// length stages, the square-root pipeline with one root bit per stage (COORD_WIDTH + 1
// stages), the face tests and the output register. Results leave in input order.
// Reset clears all valid bits and the centre registers to zero.
// The receiver cannot stall, so the pipeline advances every cycle.
module cube_face_occlusion_test_top import cfot_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  output logic                          done_o,
  output logic                          visible_o,
  output logic [2:0]                    blocking_face_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [COORD_WIDTH-1:0]        cfg_data_i
);

  localparam int W   = COORD_WIDTH;
  localparam int RW  = W + 1;
  localparam int SW  = 2 * W + 2;
  localparam int DW  = W + 1;
  localparam int LAT = W + 7;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Centre registers
  logic signed [W-1:0] centre_x_q, centre_y_q, centre_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_x_q <= '0;
      centre_y_q <= '0;
      centre_z_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_CENTRE_X: centre_x_q <= cfg_data_i;
        REG_CENTRE_Y: centre_y_q <= cfg_data_i;
        REG_CENTRE_Z: centre_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 1: ray components
  logic                 v1_q;
  logic signed [DW-1:0] dx1_q, dy1_q, dz1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    dx1_q <= DW'(point_x_i) - DW'(centre_x_q);
    dy1_q <= DW'(point_y_i) - DW'(centre_y_q);
    dz1_q <= DW'(point_z_i) - DW'(centre_z_q);
  end

  // Stage 2: squares of the magnitudes
  logic [DW-1:0] mx, my, mz;

  assign mx = dx1_q[W] ? DW'(-dx1_q) : DW'(dx1_q);
  assign my = dy1_q[W] ? DW'(-dy1_q) : DW'(dy1_q);
  assign mz = dz1_q[W] ? DW'(-dz1_q) : DW'(dz1_q);

  logic                 v2_q;
  logic [SW-1:0]        sx2_q, sy2_q, sz2_q;
  logic signed [DW-1:0] dx2_q, dy2_q, dz2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sx2_q <= SW'(mx) * SW'(mx);
    sy2_q <= SW'(my) * SW'(my);
    sz2_q <= SW'(mz) * SW'(mz);
    dx2_q <= dx1_q;
    dy2_q <= dy1_q;
    dz2_q <= dz1_q;
  end

  // Stage 3: squared length
  logic                 v3_q;
  logic [SW-1:0]        s3_q;
  logic signed [DW-1:0] dx3_q, dy3_q, dz3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_q  <= sx2_q + sy2_q + sz2_q;
    dx3_q <= dx2_q;
    dy3_q <= dy2_q;
    dz3_q <= dz2_q;
  end

  // Length by square root, ray carried alongside
  logic              v4;
  logic [RW-1:0]     len4;
  logic [3*DW-1:0]   side4;
  logic signed [DW-1:0] dx4, dy4, dz4;

  cfot_sqrt #(
    .RW     (RW),
    .SW     (SW),
    .SIDE_W (3 * DW)
  ) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v3_q),
    .radicand_i (s3_q),
    .side_i     ({dx3_q, dy3_q, dz3_q}),
    .valid_o    (v4),
    .root_o     (len4),
    .side_o     (side4)
  );

  assign dx4 = side4[3*DW-1:2*DW];
  assign dy4 = side4[2*DW-1:DW];
  assign dz4 = side4[DW-1:0];

  // Face tests, one unit per axis
  logic      vx, vy, vz;
  face_hit_t hx, hy, hz;

  cfot_axis #(.COORD_WIDTH(W)) u_axis_x (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (v4),
    .ca_i (centre_x_q), .cb_i (centre_y_q), .cc_i (centre_z_q),
    .da_i (dx4), .db_i (dy4), .dc_i (dz4), .len_i (len4),
    .valid_o (vx), .hit_o (hx)
  );

  cfot_axis #(.COORD_WIDTH(W)) u_axis_y (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (v4),
    .ca_i (centre_y_q), .cb_i (centre_x_q), .cc_i (centre_z_q),
    .da_i (dy4), .db_i (dx4), .dc_i (dz4), .len_i (len4),
    .valid_o (vy), .hit_o (hy)
  );

  cfot_axis #(.COORD_WIDTH(W)) u_axis_z (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (v4),
    .ca_i (centre_z_q), .cb_i (centre_x_q), .cc_i (centre_y_q),
    .da_i (dz4), .db_i (dx4), .dc_i (dy4), .len_i (len4),
    .valid_o (vz), .hit_o (hz)
  );

  // Pick the first blocking face in file order
  logic [2:0] face_d;

  always_comb begin
    if (hx.minus)      face_d = FACE_NEG_X;
    else if (hx.plus)  face_d = FACE_POS_X;
    else if (hy.minus) face_d = FACE_NEG_Y;
    else if (hy.plus)  face_d = FACE_POS_Y;
    else if (hz.minus) face_d = FACE_NEG_Z;
    else if (hz.plus)  face_d = FACE_POS_Z;
    else               face_d = FACE_NONE;
  end

  // Output register
  logic       done_q, visible_q;
  logic [2:0] face_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vx && vy && vz;
    end
  end

  always_ff @(posedge clk_i) begin
    visible_q <= (face_d == FACE_NONE);
    face_q    <= face_d;
  end

  assign done_o          = done_q;
  assign visible_o       = visible_q;
  assign blocking_face_o = face_q;

  // Every accepted point yields a result after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("result missing after pipeline latency");

  // Visible flag agrees with the face code
  a_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (visible_o == (blocking_face_o == FACE_NONE)))
    else $error("visible flag disagrees with face code");

  // Face code within the defined range
  a_face_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (blocking_face_o <= FACE_POS_Z))
    else $error("undefined face code");

  // A centre x write lands in its register
  a_cfg_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o && cfg_index_i == REG_CENTRE_X)
    |=> (centre_x_q == $past(cfg_data_i)))
    else $error("centre x write lost");

endmodule
